/* src/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority stack package
// Shared constants, operation and error codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default sizes of the store and its fields.
    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int PRIO_WIDTH_DEF = 8;

    // Width of the reported count field.
    localparam int COUNT_W = 5;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Error codes returned with every result.
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
    localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       load;
        logic [1:0] err;
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
    } spq_status_t;

endpackage

/* src/spq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority stack datapath
// Compare-and-shift slot array kept in descending priority order, the entry
// counter and the result register.
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  spq_cmd_t              cmd,
    input  logic [ELEM_WIDTH-1:0] elem,
    input  logic [PRIO_WIDTH-1:0] priority_req,
    output spq_status_t           status,
    output logic [ELEM_WIDTH-1:0] top_elem,
    output logic [PRIO_WIDTH-1:0] top_priority,
    output logic [COUNT_W-1:0]    count,
    output logic                  is_empty,
    output logic [1:0]            error
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ELEM_WIDTH-1:0] slot_elem_reg      [DEPTH];
    logic [PRIO_WIDTH-1:0] slot_priority_reg  [DEPTH];
    logic [ELEM_WIDTH-1:0] slot_elem_next     [DEPTH];
    logic [PRIO_WIDTH-1:0] slot_priority_next [DEPTH];
    logic [DEPTH-1:0]      higher;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    logic [ELEM_WIDTH-1:0] res_elem_reg;
    logic [PRIO_WIDTH-1:0] res_priority_reg;
    logic [COUNT_W-1:0]    res_count_reg;
    logic                  res_empty_reg;
    logic [1:0]            res_err_reg;

    // Each slot compares its own priority against the pushed one; an occupied
    // slot with a strictly higher priority stays in front of the new entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        assign higher[i] = (cnt_reg > CNT_W'(i)) && (priority_req < slot_priority_reg[i]);

        always_comb
        begin
            slot_elem_next[i]     = slot_elem_reg[i];
            slot_priority_next[i] = slot_priority_reg[i];
            if (cmd.push)
            begin
                if (!higher[i])
                begin
                    if (i == 0)
                    begin
                        slot_elem_next[i]     = elem;
                        slot_priority_next[i] = priority_req;
                    end
                    else if (higher[(i == 0) ? 0 : i - 1])
                    begin
                        slot_elem_next[i]     = elem;
                        slot_priority_next[i] = priority_req;
                    end
                    else
                    begin
                        slot_elem_next[i]     = slot_elem_reg[(i == 0) ? 0 : i - 1];
                        slot_priority_next[i] = slot_priority_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
            else if (cmd.pop && (i < DEPTH - 1))
            begin
                slot_elem_next[i]     = slot_elem_reg[(i < DEPTH - 1) ? i + 1 : i];
                slot_priority_next[i] = slot_priority_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end

        // Slot storage carries no reset; only occupied slots are ever read.
        always_ff @(posedge clk)
        begin
            slot_elem_reg[i]     <= slot_elem_next[i];
            slot_priority_reg[i] <= slot_priority_next[i];
        end
    end

    // Entry counter update.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Result register captures the front of the queue after the operation.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_empty_reg    <= (cnt_next == '0);
            res_elem_reg     <= (cnt_next == '0) ? '0 : slot_elem_next[0];
            res_priority_reg <= (cnt_next == '0) ? '0 : slot_priority_next[0];
            res_count_reg    <= COUNT_W'(cnt_next);
            res_err_reg      <= cmd.err;
        end
    end

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));

    assign top_elem     = res_elem_reg;
    assign top_priority = res_priority_reg;
    assign count        = res_count_reg;
    assign is_empty     = res_empty_reg;
    assign error        = res_err_reg;

endmodule

/* src/spq_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority stack controller
// Decodes each accepted operation into datapath commands and tracks whether
// the result register holds a result that has not been transferred.
// ----------------------------------------------------------------------------
module spq_controller
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  mode,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  spq_status_t status,
    output spq_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // A new item may enter whenever the result register is free or drains now.
    assign s_tready = (state_reg == ST_IDLE) || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_HOLD);

    // Operation decode with full and empty checks.
    always_comb
    begin
        cmd.push = 1'b0;
        cmd.pop  = 1'b0;
        cmd.load = accept;
        cmd.err  = ERR_OK;
        unique case (mode)
            MODE_PUSH:
            begin
                if (status.full)
                begin
                    cmd.err = ERR_PUSH_FULL;
                end
                else
                begin
                    cmd.push = accept;
                end
            end
            MODE_POP:
            begin
                if (status.empty)
                begin
                    cmd.err = ERR_POP_EMPTY;
                end
                else
                begin
                    cmd.pop = accept;
                end
            end
            default:
            begin
                cmd.err = ERR_OK;
            end
        endcase
    end

    // Result-pending state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!accept && m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A push and a pop never issue together.
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop issued together");

    // No push reaches a full store and no pop an empty one.
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.push && status.full) || (cmd.pop && status.empty)))
        else $error("store bound violated");

    // Every accepted item leaves a result pending in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

endmodule

/* src/sorted_priority_stack_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority stack unit
// Bounded priority queue held as a sorted register array, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser carries the operation (push, pop, query), tdata
//   carries the element and its priority. Output stream (m_*): one transfer
//   per input item with the front element, front priority and count in tdata,
//   and the empty flag and error code in tuser.
//   Entries stay ordered by descending priority; a push lands in front of the
//   first entry of equal or lower priority, so equal priorities serve newest
//   first. Pop on empty and push on full are reported and change nothing.
//   The result is registered and appears in the cycle after the input transfer.
//   Throughput: one item per cycle while results are taken; every slot
//   compares and shifts in parallel, so the slot array update keeps that rate.
//   The result register decouples the sides: a new item is taken while the
//   previous result is being transferred. When the receiver stalls, the
//   result holds and s_tready drops until it is taken.
//   Reset empties the queue and clears any pending result; slot contents
//   are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_priority_stack_unit
    import spq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEF,
    localparam int IN_DATA_W  = ((ELEM_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((ELEM_WIDTH + PRIO_WIDTH + COUNT_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // elem, priority_req
    input  logic [1:0]            s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // top_elem, top_priority, count
    output logic [2:0]            m_tuser    // is_empty, error
);

    spq_cmd_t              cmd;
    spq_status_t           status;
    logic [ELEM_WIDTH-1:0] top_elem;
    logic [PRIO_WIDTH-1:0] top_priority;
    logic [COUNT_W-1:0]    count;
    logic                  is_empty;
    logic [1:0]            error;

    spq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spq_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .elem         (s_tdata[ELEM_WIDTH-1:0]),
        .priority_req (s_tdata[ELEM_WIDTH +: PRIO_WIDTH]),
        .status       (status),
        .top_elem     (top_elem),
        .top_priority (top_priority),
        .count        (count),
        .is_empty     (is_empty),
        .error        (error)
    );

    // Pack the result fields, lowest field first, zero-filled to whole bytes.
    assign m_tdata = OUT_DATA_W'({count, top_priority, top_elem});
    assign m_tuser = {error, is_empty};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority stack unit testbench
// Drives push, pop and query items into the input stream, keeps its own
// sorted copy of the queue to predict the status result of each item, and
// compares every output transfer field by field. It runs directed corner
// cases first and then random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top
    import spq_pkg::*;
;

    localparam int QDEPTH = DEPTH_DEF;
    localparam int EW     = ELEM_WIDTH_DEF;
    localparam int PW     = PRIO_WIDTH_DEF;
    localparam int IN_W   = ((EW + PW + 7) / 8) * 8;
    localparam int OUT_W  = ((EW + PW + COUNT_W + 7) / 8) * 8;

    // Mode value 3 has no operation of its own and acts as a query.
    localparam logic [1:0] MODE_RSVD = 2'd3;

    // Status of the queue front as reported for one item.
    typedef struct packed {
        logic [EW-1:0]      top_elem;
        logic [PW-1:0]      top_prio;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic [1:0]         err;
    } queue_status_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic [1:0]       s_tuser  = MODE_QUERY;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [2:0]       m_tuser;

    // Shadow copy of the sorted store, front at index 0.
    logic [EW-1:0] shadow_elem [QDEPTH];
    logic [PW-1:0] shadow_prio [QDEPTH];
    int            shadow_count = 0;

    queue_status_t pending_status [$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            push_share     = 70;

    sorted_priority_stack_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Apply one operation to the shadow store and return the front status.
    function automatic queue_status_t apply_queue_op(input logic [1:0] mode,
                                                     input logic [EW-1:0] elem,
                                                     input logic [PW-1:0] prio);
        queue_status_t st;
        int            pos;
        st.err = ERR_OK;
        if (mode == MODE_PUSH) begin
            if (shadow_count >= QDEPTH) begin
                st.err = ERR_PUSH_FULL;
            end
            else begin
                pos = 0;
                while (pos < shadow_count && prio < shadow_prio[pos])
                    pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_elem[k] = shadow_elem[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_elem[pos] = elem;
                shadow_prio[pos] = prio;
                shadow_count++;
            end
        end
        else if (mode == MODE_POP) begin
            if (shadow_count == 0) begin
                st.err = ERR_POP_EMPTY;
            end
            else begin
                for (int k = 0; k + 1 < shadow_count; k++) begin
                    shadow_elem[k] = shadow_elem[k+1];
                    shadow_prio[k] = shadow_prio[k+1];
                end
                shadow_count--;
            end
        end
        st.is_empty = (shadow_count == 0);
        st.top_elem = st.is_empty ? '0 : shadow_elem[0];
        st.top_prio = st.is_empty ? '0 : shadow_prio[0];
        st.count    = COUNT_W'(shadow_count);
        return st;
    endfunction

    // Random stall pattern on the output side.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on each input transfer and check each output transfer.
    always @(posedge clk) begin
        queue_status_t want;
        queue_status_t got;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.top_elem = m_tdata[EW-1:0];
                got.top_prio = m_tdata[EW +: PW];
                got.count    = m_tdata[EW+PW +: COUNT_W];
                got.is_empty = m_tuser[0];
                got.err      = m_tuser[2:1];
                if (pending_status.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transfer with none outstanding", $realtime);
                end
                else begin
                    want = pending_status.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch elem %h/%h prio %h/%h count %0d/%0d ",
                                      "empty %b/%b err %0d/%0d (expected/actual)"},
                                     $realtime, want.top_elem, got.top_elem,
                                     want.top_prio, got.top_prio, want.count, got.count,
                                     want.is_empty, got.is_empty, want.err, got.err);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_status.push_back(apply_queue_op(s_tuser, s_tdata[EW-1:0],
                                                        s_tdata[EW +: PW]));
        end
    end

    // Send one item and return at the edge where it is transferred.
    task automatic send_item(input logic [1:0] mode, input logic [EW-1:0] elem,
                             input logic [PW-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_W'({prio, elem});
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold the input idle until every outstanding result has arrived.
    // The first wait lets the checker record the last input transfer.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PW-1:0] pick_priority();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: pick_priority = PW'($urandom_range(3));
            5:             pick_priority = '0;
            6:             pick_priority = '1;
            default:       pick_priority = PW'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            pick_mode = MODE_QUERY;
        else if (r < 8)
            pick_mode = MODE_RSVD;
        else if (r < 8 + push_share * 92 / 100)
            pick_mode = MODE_PUSH;
        else
            pick_mode = MODE_POP;
    endfunction

    // Corner cases: empty queue, unused mode, field extremes, ties, full queue.
    task automatic test_directed();
        send_item(MODE_QUERY, 32'hFFFF_FFFF, 8'hFF);
        send_item(MODE_POP, '0, '0);
        send_item(MODE_RSVD, 32'h1234_5678, 8'h55);
        send_item(MODE_PUSH, '0, '0);
        send_item(MODE_PUSH, 32'hFFFF_FFFF, 8'hFF);
        send_item(MODE_PUSH, 32'hA5A5_A5A5, 8'hFF);
        send_item(MODE_PUSH, 32'h5A5A_5A5A, 8'h00);
        send_item(MODE_POP, '0, '0);
        for (int i = 0; i < 13; i++)
            send_item(MODE_PUSH, $urandom, PW'($urandom_range(3) * 85));
        send_item(MODE_PUSH, 32'hDEAD_BEEF, 8'hFF);
        send_item(MODE_RSVD, '0, '0);
        send_item(MODE_POP, '0, '0);
        send_item(MODE_QUERY, '0, '0);
        drain_results();
    endtask

    // Random traffic that swings between filling and draining the queue.
    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 48 == 0)
                push_share = (push_share > 50) ? 25 : 75;
            send_item(pick_mode(), $urandom, pick_priority());
        end
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(350, 0, 0);
        test_random(350, 69, 0);
        test_random(350, 0, 69);
        test_random(350, 36, 36);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_status.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
src/spq_pkg.sv
src/spq_datapath.sv
src/spq_controller.sv
src/sorted_priority_stack_unit.sv
tb/sv/tb_top.sv
